>>> sv/idt_pkg.sv
// Shared types, register indexes and constants for the interrupt dispatcher and timer.
// No dependencies; the timer, dispatcher and top level refer to this package by scoped names.
`default_nettype none

package idt_pkg;

  localparam int NUM_IRQ = 5;
  localparam int TIMER_IRQ_BIT = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMER_ENABLE     = 2'd0;
  localparam logic [1:0] REG_TIMER_RATE       = 2'd1;
  localparam logic [1:0] REG_TIMER_RELOAD     = 2'd2;
  localparam logic [1:0] REG_INTERRUPT_ENABLE = 2'd3;

  // Master enable commands; IME_NONE and the unused fourth code mean no command.
  localparam logic [1:0] IME_NONE    = 2'd0;
  localparam logic [1:0] IME_ENABLE  = 2'd1;
  localparam logic [1:0] IME_DISABLE = 2'd2;

  // Timer rate select codes.
  localparam logic [1:0] RATE_64 = 2'd0;
  localparam logic [1:0] RATE_1  = 2'd1;
  localparam logic [1:0] RATE_4  = 2'd2;
  localparam logic [1:0] RATE_16 = 2'd3;

  localparam logic [6:0] VECTOR_BASE = 7'h40;
  localparam logic [7:0] COUNTER_MAX = 8'hFF;

  typedef struct packed {
    logic       timer_enable;
    logic [1:0] timer_rate;
    logic [7:0] timer_reload;
    logic [4:0] interrupt_enable;
  } cfg_t;

  typedef struct packed {
    logic       timer_req;
    logic [7:0] divider;
    logic [7:0] counter;
  } tmr_status_t;

  typedef struct packed {
    logic        dispatch;
    logic [6:0]  vector_address;
    logic [15:0] return_address;
    logic [4:0]  pending;
    logic        master_enable;
  } irq_status_t;

  // Base ticks per timer count for each rate code.
  function automatic logic [6:0] rate_period(input logic [1:0] rate);
    logic [6:0] period;
    case (rate)
      RATE_64: period = 7'd64;
      RATE_1:  period = 7'd1;
      RATE_4:  period = 7'd4;
      RATE_16: period = 7'd16;
      default: period = 7'd64;
    endcase
    return period;
  endfunction

endpackage

`default_nettype wire

>>> sv/idt_timer.sv
// Divider and programmable timer counter with their tick accumulators.
// Depends on idt_pkg for the configuration and status structs.
`default_nettype none

module idt_timer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                tick,
  input  wire idt_pkg::cfg_t       cfg,
  output idt_pkg::tmr_status_t     status
);

  logic [3:0] div_accum, div_accum_next;
  logic [7:0] div_count, div_count_next;
  logic [6:0] tmr_accum, tmr_accum_next;
  logic [7:0] tmr_count, tmr_count_next;
  logic [6:0] acc;
  logic       timer_req;

  always_comb begin
    acc            = tmr_accum + 7'd1;
    div_accum_next = div_accum;
    div_count_next = div_count;
    tmr_accum_next = tmr_accum;
    tmr_count_next = tmr_count;
    timer_req      = 1'b0;
    if (tick) begin
      div_accum_next = div_accum + 4'd1;
      if (div_accum_next == 4'd0) begin
        div_count_next = div_count + 8'd1;
      end
      if (cfg.timer_enable) begin
        if (acc >= idt_pkg::rate_period(cfg.timer_rate)) begin
          tmr_accum_next = 7'd0;
          if (tmr_count == idt_pkg::COUNTER_MAX) begin
            tmr_count_next = cfg.timer_reload;
            timer_req      = 1'b1;
          end else begin
            tmr_count_next = tmr_count + 8'd1;
          end
        end else begin
          tmr_accum_next = acc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_accum <= 4'd0;
      div_count <= 8'd0;
      tmr_accum <= 7'd0;
      tmr_count <= 8'd0;
    end else if (step) begin
      div_accum <= div_accum_next;
      div_count <= div_count_next;
      tmr_accum <= tmr_accum_next;
      tmr_count <= tmr_count_next;
    end
  end

  assign status.timer_req = timer_req;
  assign status.divider   = div_count_next;
  assign status.counter   = tmr_count_next;

endmodule

`default_nettype wire

>>> sv/idt_intc.sv
// Interrupt request flags, master enable and priority dispatch.
// Depends on idt_pkg for constants and the status struct.
`default_nettype none

module idt_intc (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [15:0]         program_counter,
  input  wire logic [1:0]          ime_command,
  input  wire logic [4:0]          irq_set,
  input  wire logic [4:0]          irq_clear,
  input  wire logic [4:0]          interrupt_enable,
  input  wire logic                timer_req,
  output idt_pkg::irq_status_t     status
);

  logic [4:0] pending, pending_next;
  logic       master_enable, master_enable_next;
  logic       enable_pending, enable_pending_next;
  logic [4:0] active;
  logic [2:0] sel;
  logic       taken;
  logic [4:0] after_dispatch;
  logic [4:0] timer_mask;

  always_comb begin
    active = pending & interrupt_enable;
    taken  = master_enable && (active != 5'd0);
    sel    = 3'd0;
    // Lowest set bit has the highest priority.
    for (int i = idt_pkg::NUM_IRQ - 1; i >= 0; i--) begin
      if (active[i]) begin
        sel = 3'(i);
      end
    end

    after_dispatch      = pending;
    master_enable_next  = master_enable;
    enable_pending_next = enable_pending;
    if (taken) begin
      after_dispatch[sel] = 1'b0;
      master_enable_next  = 1'b0;
      enable_pending_next = 1'b0;
    end
    if (enable_pending_next) begin
      master_enable_next  = 1'b1;
      enable_pending_next = 1'b0;
    end

    timer_mask = 5'd0;
    timer_mask[idt_pkg::TIMER_IRQ_BIT] = timer_req;
    pending_next = (after_dispatch & ~irq_clear) | irq_set | timer_mask;

    if (ime_command == idt_pkg::IME_ENABLE) begin
      enable_pending_next = 1'b1;
    end else if (ime_command == idt_pkg::IME_DISABLE) begin
      master_enable_next  = 1'b0;
      enable_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending        <= 5'd0;
      master_enable  <= 1'b1;
      enable_pending <= 1'b0;
    end else if (step) begin
      pending        <= pending_next;
      master_enable  <= master_enable_next;
      enable_pending <= enable_pending_next;
    end
  end

  assign status.dispatch       = taken;
  assign status.vector_address = taken ? {1'b1, sel, 3'b000} : 7'd0;
  assign status.return_address = taken ? program_counter : 16'd0;
  assign status.pending        = pending_next;
  assign status.master_enable  = master_enable_next;

endmodule

`default_nettype wire

>>> sv/interrupt_dispatch_and_timer.sv
// Top level of the interrupt dispatcher with divider and programmable timer.
// Depends on idt_pkg, idt_timer and idt_intc.
//
// Usage: each request on the input channel is one step of the machine: a
// base-tick flag, the current program counter, a master enable command and
// interrupt raise and clear masks. Every accepted request yields exactly one
// result on the output channel: whether an interrupt was dispatched, its
// handler vector and return address, and the request flags, master enable,
// divider and timer counter as they stand after the step.
// Both channels use valid and stall; a transfer happens at a clock edge where
// valid is high and stall is low. The result is registered, and one request
// is taken every cycle while in_stall is low: the state update is a single
// pass of short logic into the state and result registers. in_stall rises
// only while a finished result waits and out_stall is high, so a stalled
// receiver holds back the sender after one result is buffered. Configuration
// registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while the block is idle, which the block does not
// enforce. Synchronous reset clears the output channel, all counters, the
// request flags and the configuration, and sets the master enable.
`default_nettype none

module interrupt_dispatch_and_timer (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        tick,
  input  wire logic [15:0] program_counter,
  input  wire logic [1:0]  ime_command,
  input  wire logic [4:0]  irq_set,
  input  wire logic [4:0]  irq_clear,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             dispatch,
  output logic [6:0]       vector_address,
  output logic [15:0]      return_address,
  output logic [4:0]       pending_out,
  output logic             master_enable_out,
  output logic [7:0]       divider_value,
  output logic [7:0]       counter_value
);

  idt_pkg::cfg_t        cfg;
  idt_pkg::tmr_status_t tmr;
  idt_pkg::irq_status_t irq;
  logic                 step;

  // A new request enters whenever the result register is empty or drains
  // in the same cycle.
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        idt_pkg::REG_TIMER_ENABLE:     cfg.timer_enable     <= cfg_data[0];
        idt_pkg::REG_TIMER_RATE:       cfg.timer_rate       <= cfg_data[1:0];
        idt_pkg::REG_TIMER_RELOAD:     cfg.timer_reload     <= cfg_data;
        idt_pkg::REG_INTERRUPT_ENABLE: cfg.interrupt_enable <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  idt_timer u_timer (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .tick   (tick),
    .cfg    (cfg),
    .status (tmr)
  );

  // The timer request feeds the flag update of the same step.
  idt_intc u_intc (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .program_counter  (program_counter),
    .ime_command      (ime_command),
    .irq_set          (irq_set),
    .irq_clear        (irq_clear),
    .interrupt_enable (cfg.interrupt_enable),
    .timer_req        (tmr.timer_req),
    .status           (irq)
  );

  // Result register: valid is control state, the payload loads on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      dispatch          <= irq.dispatch;
      vector_address    <= irq.vector_address;
      return_address    <= irq.return_address;
      pending_out       <= irq.pending;
      master_enable_out <= irq.master_enable;
      divider_value     <= tmr.divider;
      counter_value     <= tmr.counter;
    end
  end

endmodule

`default_nettype wire

>>> sv/idt_checker.sv
// Port-level checks for interrupt_dispatch_and_timer, and the bind that attaches them.
// Depends only on the top level's ports.
`default_nettype none

module idt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        dispatch,
  input wire logic [6:0]  vector_address,
  input wire logic [15:0] return_address,
  input wire logic        master_enable_out,
  input wire logic [7:0]  counter_value
);

  // A dispatch always reports a legal vector and leaves the master enable off.
  a_dispatch_vector: assert property (@(posedge clk) disable iff (rst)
    out_valid && dispatch |-> !master_enable_out &&
      (vector_address == 7'h40 || vector_address == 7'h48 || vector_address == 7'h50 ||
       vector_address == 7'h58 || vector_address == 7'h60))
    else $error("dispatch with bad vector or master enable still set");

  // Without a dispatch the vector and return address read zero.
  a_no_dispatch_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dispatch |-> vector_address == 7'd0 && return_address == 16'd0)
    else $error("vector or return address set without dispatch");

  // The sender is only held back while a result is waiting on a stalled receiver.
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled while result register can drain");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(counter_value) && $stable(dispatch))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind interrupt_dispatch_and_timer idt_checker u_idt_checker (
  .clk               (clk),
  .rst               (rst),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .dispatch          (dispatch),
  .vector_address    (vector_address),
  .return_address    (return_address),
  .master_enable_out (master_enable_out),
  .counter_value     (counter_value)
);

`default_nettype wire
